// File: sv/assert_macros.svh
// Assertion helpers for the sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that prop holds on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert that a condition implies a consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: sv/ata_seq_pkg.sv
// ----------------------------------------------------------------------------
// ata_seq_pkg
// Types and constants shared by the ATA PIO LBA28 host sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
package ata_seq_pkg;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  op;
    logic [31:0] lba;
    logic [15:0] sector_count;
    logic        has_buffer;
    logic [15:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic        bus_write;
    logic [3:0]  bus_reg;
    logic        bus_wide;
    logic [15:0] out_data;
    logic [3:0]  done_code;
    logic [7:0]  last_status;
    logic [7:0]  last_error;
    logic        last;
  } out_item_t;

  // Result item without the held bytes and the last marker.
  typedef struct packed {
    logic [1:0]  out_kind;
    logic        bus_write;
    logic [3:0]  bus_reg;
    logic        bus_wide;
    logic [15:0] out_data;
    logic [3:0]  done_code;
  } res_t;

  localparam int unsigned MaxRes = 8;

  // Batch of results caused by one item.
  typedef struct packed {
    res_t [MaxRes-1:0] res;
    logic [3:0]        count;
    logic [7:0]        status;
    logic [7:0]        error;
  } batch_t;

  localparam logic [1:0] REQ_CMD  = 2'd0;
  localparam logic [1:0] REQ_RESP = 2'd1;
  localparam logic [1:0] REQ_WORD = 2'd2;

  localparam logic [1:0] OP_IDENT = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  localparam logic [1:0] KIND_BUS  = 2'd0;
  localparam logic [1:0] KIND_RDW  = 2'd1;
  localparam logic [1:0] KIND_REQW = 2'd2;
  localparam logic [1:0] KIND_DONE = 2'd3;

  localparam logic [3:0] DC_OK      = 4'd0;
  localparam logic [3:0] DC_NRDY    = 4'd1;
  localparam logic [3:0] DC_NOBUF   = 4'd2;
  localparam logic [3:0] DC_LBA     = 4'd3;
  localparam logic [3:0] DC_NODEV   = 4'd4;
  localparam logic [3:0] DC_NOTATA  = 4'd5;
  localparam logic [3:0] DC_BSYTO   = 4'd6;
  localparam logic [3:0] DC_DRQTO   = 4'd7;
  localparam logic [3:0] DC_DEVERR  = 4'd8;
  localparam logic [3:0] DC_DEVFLT  = 4'd9;
  localparam logic [3:0] DC_IDFAIL  = 4'd10;

  localparam logic [3:0] REG_DATA = 4'd0;
  localparam logic [3:0] REG_ERR  = 4'd1;
  localparam logic [3:0] REG_CNT  = 4'd2;
  localparam logic [3:0] REG_LO   = 4'd3;
  localparam logic [3:0] REG_MID  = 4'd4;
  localparam logic [3:0] REG_HI   = 4'd5;
  localparam logic [3:0] REG_DEV  = 4'd6;
  localparam logic [3:0] REG_CMD  = 4'd7;
  localparam logic [3:0] REG_ALT  = 4'd8;

  localparam logic [7:0] ST_ERR = 8'h01;
  localparam logic [7:0] ST_DRQ = 8'h08;
  localparam logic [7:0] ST_DF  = 8'h20;
  localparam logic [7:0] ST_BSY = 8'h80;

  localparam logic [7:0] DEV_LBA_MASTER = 8'hE0;
  localparam logic [7:0] CMD_READ  = 8'h20;
  localparam logic [7:0] CMD_WRITE = 8'h30;
  localparam logic [7:0] CMD_IDENT = 8'hEC;
  localparam logic [31:0] MAX_LBA  = 32'h0FFF_FFFF;

  localparam logic CFG_POLL   = 1'b0;
  localparam logic CFG_SETTLE = 1'b1;
  localparam logic [19:0] POLL_RESET   = 20'd1000000;
  localparam logic [3:0]  SETTLE_RESET = 4'd4;

  typedef enum logic [18:0] {
    PH_IDLE      = 19'h00001,
    PH_SETTLE    = 19'h00002,
    PH_SELST     = 19'h00004,
    PH_BSY_A     = 19'h00008,
    PH_ID_STATUS = 19'h00010,
    PH_ID_BSY    = 19'h00020,
    PH_ID_MID    = 19'h00040,
    PH_ID_HIGH   = 19'h00080,
    PH_DRQ       = 19'h00100,
    PH_DRQ_ERR   = 19'h00200,
    PH_DRQ_TO    = 19'h00400,
    PH_ID_DATA   = 19'h00800,
    PH_BSY_B     = 19'h01000,
    PH_RD_ST     = 19'h02000,
    PH_ERR_RD    = 19'h04000,
    PH_RD_DATA   = 19'h08000,
    PH_WR_DATA   = 19'h10000,
    PH_BSY_C     = 19'h20000,
    PH_WR_ST     = 19'h40000
  } phase_e;

endpackage
`default_nettype wire

// File: sv/ata_seq_engine.sv
// ----------------------------------------------------------------------------
// ata_seq_engine
// Front part: takes one input item per cycle while step_i is high, steps the
// sequencer and emits the batch of results that item causes.
// ----------------------------------------------------------------------------
`default_nettype none
module ata_seq_engine #(
  parameter int unsigned WordsPerSector = 256,
  parameter int unsigned CountBits      = 16
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     step_i,
  input  ata_seq_pkg::in_item_t   item_i,
  input  wire  [19:0]             poll_limit_i,
  input  wire  [3:0]              settle_reads_i,
  output ata_seq_pkg::batch_t     batch_o,
  output logic                    idle_o
);

  localparam int unsigned WiBits = $clog2(WordsPerSector + 1);

  ata_seq_pkg::phase_e  phase_q, phase_d;
  logic                 ready_q, ready_d;
  logic [1:0]           cop_q, cop_d;
  logic [32:0]          sector_q, sector_d;
  logic [CountBits-1:0] left_q, left_d;
  logic [WiBits-1:0]    wi_q, wi_d;
  logic [19:0]          poll_q, poll_d;
  logic [3:0]           settle_q, settle_d;
  logic [7:0]           status_q, status_d;
  logic [7:0]           error_q, error_d;
  logic                 sig_q, sig_d;

  ata_seq_pkg::res_t [ata_seq_pkg::MaxRes-1:0] res;
  logic [3:0] n;
  logic [19:0] lim;
  logic [7:0] s;
  logic [WiBits-1:0] wi_inc;
  logic [32:0] sec_inc;
  logic [CountBits-1:0] left_dec;
  logic [CountBits-1:0] cnt;

  assign lim      = (poll_limit_i == 20'd0) ? 20'd1 : poll_limit_i;
  assign s        = item_i.data_value[7:0];
  assign wi_inc   = wi_q + WiBits'(1);
  assign sec_inc  = sector_q + 33'd1;
  assign left_dec = left_q - CountBits'(1);
  assign idle_o   = (phase_q == ata_seq_pkg::PH_IDLE);
  assign cnt      = CountBits'(item_i.sector_count);

  function automatic ata_seq_pkg::res_t mk(logic [1:0] k, logic bw, logic [3:0] r, logic w,
                                           logic [15:0] d, logic [3:0] c);
    ata_seq_pkg::res_t x;
    x.out_kind = k; x.bus_write = bw; x.bus_reg = r; x.bus_wide = w;
    x.out_data = d; x.done_code = c;
    return x;
  endfunction

  // Step the sequencer by one input item.
  always_comb begin
    logic [3:0] k;
    logic       go_sector;
    logic [32:0] ssec;
    logic [3:0] sset;
    logic       do_after;
    logic       fin;
    logic [3:0] fcode;
    k = '0;
    go_sector = 1'b0;
    ssec = sector_q;
    sset = settle_q;
    do_after = 1'b0;
    fin = 1'b0;
    fcode = ata_seq_pkg::DC_OK;
    res = '0;
    phase_d = phase_q; ready_d = ready_q; cop_d = cop_q; sector_d = sector_q;
    left_d = left_q; wi_d = wi_q; poll_d = poll_q; settle_d = settle_q;
    status_d = status_q; error_d = error_q; sig_d = sig_q;

    if (step_i) begin
      unique case (item_i.req_type)
        ata_seq_pkg::REQ_CMD: begin
          if (phase_q == ata_seq_pkg::PH_IDLE) begin
            if (item_i.op == ata_seq_pkg::OP_IDENT) begin
              cop_d = ata_seq_pkg::OP_IDENT;
              res[k[2:0]] = mk(ata_seq_pkg::KIND_BUS, 1'b1, ata_seq_pkg::REG_DEV, 1'b0,
                               {8'h00, ata_seq_pkg::DEV_LBA_MASTER}, ata_seq_pkg::DC_OK);
              k = k + 4'd1;
              sset = settle_reads_i;
              do_after = 1'b1;
            end else if (item_i.op != 2'd3) begin
              cop_d = item_i.op;
              if (!ready_q) begin
                fin = 1'b1; fcode = ata_seq_pkg::DC_NRDY;
              end else if (!item_i.has_buffer) begin
                fin = 1'b1; fcode = ata_seq_pkg::DC_NOBUF;
              end else if (item_i.lba > ata_seq_pkg::MAX_LBA) begin
                fin = 1'b1; fcode = ata_seq_pkg::DC_LBA;
              end else if (cnt == '0) begin
                fin = 1'b1; fcode = ata_seq_pkg::DC_OK;
              end else begin
                ssec = {1'b0, item_i.lba};
                sector_d = ssec;
                left_d = cnt;
                go_sector = 1'b1;
              end
            end
          end
        end
        ata_seq_pkg::REQ_RESP: begin
          if (phase_q != ata_seq_pkg::PH_IDLE && phase_q != ata_seq_pkg::PH_WR_DATA) begin
            unique case (phase_q)
              ata_seq_pkg::PH_SETTLE: begin
                sset = settle_q - 4'd1;
                do_after = 1'b1;
              end
              ata_seq_pkg::PH_SELST: begin
                poll_d = 20'd1;
                res[k[2:0]] = mk(ata_seq_pkg::KIND_BUS, 1'b0, ata_seq_pkg::REG_CMD, 1'b0,
                                 '0, '0);
                k = k + 4'd1;
                phase_d = ata_seq_pkg::PH_BSY_A;
              end
              ata_seq_pkg::PH_BSY_A: begin
                if ((s & ata_seq_pkg::ST_BSY) == 8'h00) begin
                  res[0] = mk(ata_seq_pkg::KIND_BUS, 1'b1, ata_seq_pkg::REG_CNT, 1'b0,
                              16'h0001, '0);
                  res[1] = mk(ata_seq_pkg::KIND_BUS, 1'b1, ata_seq_pkg::REG_LO, 1'b0,
                              {8'h00, sector_q[7:0]}, '0);
                  res[2] = mk(ata_seq_pkg::KIND_BUS, 1'b1, ata_seq_pkg::REG_MID, 1'b0,
                              {8'h00, sector_q[15:8]}, '0);
                  res[3] = mk(ata_seq_pkg::KIND_BUS, 1'b1, ata_seq_pkg::REG_HI, 1'b0,
                              {8'h00, sector_q[23:16]}, '0);
                  res[4] = mk(ata_seq_pkg::KIND_BUS, 1'b1, ata_seq_pkg::REG_CMD, 1'b0,
                              {8'h00, (cop_q == ata_seq_pkg::OP_READ) ?
                               ata_seq_pkg::CMD_READ : ata_seq_pkg::CMD_WRITE}, '0);
                  res[5] = mk(ata_seq_pkg::KIND_BUS, 1'b0, ata_seq_pkg::REG_CMD, 1'b0, '0, '0);
                  k = 4'd6;
                  poll_d = 20'd1;
                  phase_d = (cop_q == ata_seq_pkg::OP_READ) ? ata_seq_pkg::PH_BSY_B
                                                             : ata_seq_pkg::PH_DRQ;
                end else if (poll_q >= lim) begin
                  fin = 1'b1; fcode = ata_seq_pkg::DC_BSYTO;
                end else begin
                  poll_d = poll_q + 20'd1;
                  res[k[2:0]] = mk(ata_seq_pkg::KIND_BUS, 1'b0, ata_seq_pkg::REG_CMD, 1'b0,
                                   '0, '0);
                  k = k + 4'd1;
                end
              end
              ata_seq_pkg::PH_ID_STATUS: begin
                if (s == 8'h00) begin
                  fin = 1'b1; fcode = ata_seq_pkg::DC_NODEV;
                end else begin
                  poll_d = 20'd1;
                  res[k[2:0]] = mk(ata_seq_pkg::KIND_BUS, 1'b0, ata_seq_pkg::REG_CMD, 1'b0,
                                   '0, '0);
                  k = k + 4'd1;
                  phase_d = ata_seq_pkg::PH_ID_BSY;
                end
              end
              ata_seq_pkg::PH_ID_BSY: begin
                if ((s & ata_seq_pkg::ST_BSY) == 8'h00) begin
                  res[k[2:0]] = mk(ata_seq_pkg::KIND_BUS, 1'b0, ata_seq_pkg::REG_MID, 1'b0,
                                   '0, '0);
                  k = k + 4'd1;
                  phase_d = ata_seq_pkg::PH_ID_MID;
                end else if (poll_q >= lim) begin
                  fin = 1'b1; fcode = ata_seq_pkg::DC_BSYTO;
                end else begin
                  poll_d = poll_q + 20'd1;
                  res[k[2:0]] = mk(ata_seq_pkg::KIND_BUS, 1'b0, ata_seq_pkg::REG_CMD, 1'b0,
                                   '0, '0);
                  k = k + 4'd1;
                end
              end
              ata_seq_pkg::PH_ID_MID: begin
                sig_d = (s != 8'h00);
                res[k[2:0]] = mk(ata_seq_pkg::KIND_BUS, 1'b0, ata_seq_pkg::REG_HI, 1'b0,
                                 '0, '0);
                k = k + 4'd1;
                phase_d = ata_seq_pkg::PH_ID_HIGH;
              end
              ata_seq_pkg::PH_ID_HIGH: begin
                if (sig_q || s != 8'h00) begin
                  fin = 1'b1; fcode = ata_seq_pkg::DC_NOTATA;
                end else begin
                  poll_d = 20'd1;
                  res[k[2:0]] = mk(ata_seq_pkg::KIND_BUS, 1'b0, ata_seq_pkg::REG_CMD, 1'b0,
                                   '0, '0);
                  k = k + 4'd1;
                  phase_d = ata_seq_pkg::PH_DRQ;
                end
              end
              ata_seq_pkg::PH_DRQ: begin
                if ((s & ata_seq_pkg::ST_ERR) != 8'h00) begin
                  status_d = s;
                  res[k[2:0]] = mk(ata_seq_pkg::KIND_BUS, 1'b0, ata_seq_pkg::REG_ERR, 1'b0,
                                   '0, '0);
                  k = k + 4'd1;
                  phase_d = ata_seq_pkg::PH_DRQ_ERR;
                end else if ((s & ata_seq_pkg::ST_DF) != 8'h00) begin
                  status_d = s;
                  fin = 1'b1;
                  fcode = (cop_q == ata_seq_pkg::OP_IDENT) ? ata_seq_pkg::DC_IDFAIL
                                                          : ata_seq_pkg::DC_DEVFLT;
                end else if ((s & ata_seq_pkg::ST_BSY) == 8'h00 &&
                             (s & ata_seq_pkg::ST_DRQ) != 8'h00) begin
                  wi_d = '0;
                  if (cop_q == ata_seq_pkg::OP_WRITE) begin
                    res[k[2:0]] = mk(ata_seq_pkg::KIND_REQW, 1'b0, '0, 1'b0, '0, '0);
                    phase_d = ata_seq_pkg::PH_WR_DATA;
                  end else begin
                    res[k[2:0]] = mk(ata_seq_pkg::KIND_BUS, 1'b0, ata_seq_pkg::REG_DATA, 1'b1,
                                     '0, '0);
                    phase_d = (cop_q == ata_seq_pkg::OP_IDENT) ? ata_seq_pkg::PH_ID_DATA
                                                              : ata_seq_pkg::PH_RD_DATA;
                  end
                  k = k + 4'd1;
                end else if (poll_q >= lim) begin
                  res[k[2:0]] = mk(ata_seq_pkg::KIND_BUS, 1'b0, ata_seq_pkg::REG_CMD, 1'b0,
                                   '0, '0);
                  k = k + 4'd1;
                  phase_d = ata_seq_pkg::PH_DRQ_TO;
                end else begin
                  poll_d = poll_q + 20'd1;
                  res[k[2:0]] = mk(ata_seq_pkg::KIND_BUS, 1'b0, ata_seq_pkg::REG_CMD, 1'b0,
                                   '0, '0);
                  k = k + 4'd1;
                end
              end
              ata_seq_pkg::PH_DRQ_ERR: begin
                error_d = s;
                fin = 1'b1;
                fcode = (cop_q == ata_seq_pkg::OP_IDENT) ? ata_seq_pkg::DC_IDFAIL
                                                        : ata_seq_pkg::DC_DEVERR;
              end
              ata_seq_pkg::PH_DRQ_TO: begin
                status_d = s;
                fin = 1'b1;
                fcode = (cop_q == ata_seq_pkg::OP_IDENT) ? ata_seq_pkg::DC_IDFAIL
                                                        : ata_seq_pkg::DC_DRQTO;
              end
              ata_seq_pkg::PH_ID_DATA: begin
                wi_d = wi_inc;
                if (wi_inc < WiBits'(WordsPerSector)) begin
                  res[k[2:0]] = mk(ata_seq_pkg::KIND_BUS, 1'b0, ata_seq_pkg::REG_DATA, 1'b1,
                                   '0, '0);
                  k = k + 4'd1;
                end else begin
                  ready_d = 1'b1;
                  fin = 1'b1; fcode = ata_seq_pkg::DC_OK;
                end
              end
              ata_seq_pkg::PH_BSY_B, ata_seq_pkg::PH_BSY_C: begin
                if ((s & ata_seq_pkg::ST_BSY) == 8'h00) begin
                  res[k[2:0]] = mk(ata_seq_pkg::KIND_BUS, 1'b0, ata_seq_pkg::REG_CMD, 1'b0,
                                   '0, '0);
                  k = k + 4'd1;
                  phase_d = (phase_q == ata_seq_pkg::PH_BSY_B) ? ata_seq_pkg::PH_RD_ST
                                                              : ata_seq_pkg::PH_WR_ST;
                end else if (poll_q >= lim) begin
                  fin = 1'b1; fcode = ata_seq_pkg::DC_BSYTO;
                end else begin
                  poll_d = poll_q + 20'd1;
                  res[k[2:0]] = mk(ata_seq_pkg::KIND_BUS, 1'b0, ata_seq_pkg::REG_CMD, 1'b0,
                                   '0, '0);
                  k = k + 4'd1;
                end
              end
              ata_seq_pkg::PH_RD_ST, ata_seq_pkg::PH_WR_ST: begin
                status_d = s;
                if ((s & ata_seq_pkg::ST_ERR) != 8'h00) begin
                  res[k[2:0]] = mk(ata_seq_pkg::KIND_BUS, 1'b0, ata_seq_pkg::REG_ERR, 1'b0,
                                   '0, '0);
                  k = k + 4'd1;
                  phase_d = ata_seq_pkg::PH_ERR_RD;
                end else if ((s & ata_seq_pkg::ST_DF) != 8'h00) begin
                  fin = 1'b1; fcode = ata_seq_pkg::DC_DEVFLT;
                end else if (phase_q == ata_seq_pkg::PH_WR_ST) begin
                  left_d = left_dec;
                  sector_d = sec_inc;
                  if (left_dec == '0) begin
                    fin = 1'b1; fcode = ata_seq_pkg::DC_OK;
                  end else begin
                    ssec = sec_inc; go_sector = 1'b1;
                  end
                end else if ((s & ata_seq_pkg::ST_DRQ) != 8'h00) begin
                  wi_d = '0;
                  res[k[2:0]] = mk(ata_seq_pkg::KIND_BUS, 1'b0, ata_seq_pkg::REG_DATA, 1'b1,
                                   '0, '0);
                  k = k + 4'd1;
                  phase_d = ata_seq_pkg::PH_RD_DATA;
                end else begin
                  poll_d = 20'd1;
                  res[k[2:0]] = mk(ata_seq_pkg::KIND_BUS, 1'b0, ata_seq_pkg::REG_CMD, 1'b0,
                                   '0, '0);
                  k = k + 4'd1;
                  phase_d = ata_seq_pkg::PH_DRQ;
                end
              end
              ata_seq_pkg::PH_ERR_RD: begin
                error_d = s;
                fin = 1'b1; fcode = ata_seq_pkg::DC_DEVERR;
              end
              ata_seq_pkg::PH_RD_DATA: begin
                res[k[2:0]] = mk(ata_seq_pkg::KIND_RDW, 1'b0, '0, 1'b0, item_i.data_value,
                                 '0);
                k = k + 4'd1;
                wi_d = wi_inc;
                if (wi_inc < WiBits'(WordsPerSector)) begin
                  res[k[2:0]] = mk(ata_seq_pkg::KIND_BUS, 1'b0, ata_seq_pkg::REG_DATA, 1'b1,
                                   '0, '0);
                  k = k + 4'd1;
                end else begin
                  left_d = left_dec;
                  sector_d = sec_inc;
                  if (left_dec == '0) begin
                    fin = 1'b1; fcode = ata_seq_pkg::DC_OK;
                  end else begin
                    ssec = sec_inc; go_sector = 1'b1;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        ata_seq_pkg::REQ_WORD: begin
          if (phase_q == ata_seq_pkg::PH_WR_DATA) begin
            res[k[2:0]] = mk(ata_seq_pkg::KIND_BUS, 1'b1, ata_seq_pkg::REG_DATA, 1'b1,
                             item_i.data_value, '0);
            k = k + 4'd1;
            wi_d = wi_inc;
            if (wi_inc < WiBits'(WordsPerSector)) begin
              res[k[2:0]] = mk(ata_seq_pkg::KIND_REQW, 1'b0, '0, 1'b0, '0, '0);
            end else begin
              poll_d = 20'd1;
              res[k[2:0]] = mk(ata_seq_pkg::KIND_BUS, 1'b0, ata_seq_pkg::REG_CMD, 1'b0,
                               '0, '0);
              phase_d = ata_seq_pkg::PH_BSY_C;
            end
            k = k + 4'd1;
          end
        end
        default: begin
        end
      endcase

      // Open a sector: range check, then drive select.
      if (go_sector) begin
        if (ssec > {1'b0, ata_seq_pkg::MAX_LBA}) begin
          fin = 1'b1; fcode = ata_seq_pkg::DC_LBA;
        end else begin
          res[k[2:0]] = mk(ata_seq_pkg::KIND_BUS, 1'b1, ata_seq_pkg::REG_DEV, 1'b0,
                           {8'h00, ata_seq_pkg::DEV_LBA_MASTER | {4'h0, ssec[27:24]}}, '0);
          k = k + 4'd1;
          sset = settle_reads_i;
          do_after = 1'b1;
        end
      end

      // Settle reads, then the command-specific start.
      if (do_after) begin
        settle_d = sset;
        if (sset != 4'd0) begin
          res[k[2:0]] = mk(ata_seq_pkg::KIND_BUS, 1'b0, ata_seq_pkg::REG_ALT, 1'b0, '0, '0);
          k = k + 4'd1;
          phase_d = ata_seq_pkg::PH_SETTLE;
        end else if (cop_d == ata_seq_pkg::OP_IDENT) begin
          res[k[2:0]] = mk(ata_seq_pkg::KIND_BUS, 1'b1, ata_seq_pkg::REG_CNT, 1'b0, '0, '0);
          res[k[2:0]+3'd1] = mk(ata_seq_pkg::KIND_BUS, 1'b1, ata_seq_pkg::REG_LO, 1'b0,
                                '0, '0);
          res[k[2:0]+3'd2] = mk(ata_seq_pkg::KIND_BUS, 1'b1, ata_seq_pkg::REG_MID, 1'b0,
                                '0, '0);
          res[k[2:0]+3'd3] = mk(ata_seq_pkg::KIND_BUS, 1'b1, ata_seq_pkg::REG_HI, 1'b0,
                                '0, '0);
          res[k[2:0]+3'd4] = mk(ata_seq_pkg::KIND_BUS, 1'b1, ata_seq_pkg::REG_CMD, 1'b0,
                                {8'h00, ata_seq_pkg::CMD_IDENT}, '0);
          res[k[2:0]+3'd5] = mk(ata_seq_pkg::KIND_BUS, 1'b0, ata_seq_pkg::REG_CMD, 1'b0,
                                '0, '0);
          k = k + 4'd6;
          phase_d = ata_seq_pkg::PH_ID_STATUS;
        end else if (cop_d == ata_seq_pkg::OP_READ) begin
          res[k[2:0]] = mk(ata_seq_pkg::KIND_BUS, 1'b0, ata_seq_pkg::REG_CMD, 1'b0, '0, '0);
          k = k + 4'd1;
          phase_d = ata_seq_pkg::PH_SELST;
        end else begin
          poll_d = 20'd1;
          res[k[2:0]] = mk(ata_seq_pkg::KIND_BUS, 1'b0, ata_seq_pkg::REG_CMD, 1'b0, '0, '0);
          k = k + 4'd1;
          phase_d = ata_seq_pkg::PH_BSY_A;
        end
      end

      // Completion item closes the command.
      if (fin) begin
        res[k[2:0]] = mk(ata_seq_pkg::KIND_DONE, 1'b0, '0, 1'b0, '0, fcode);
        k = k + 4'd1;
        phase_d = ata_seq_pkg::PH_IDLE;
      end
    end
    n = k;
  end

  assign batch_o.res    = res;
  assign batch_o.count  = n;
  assign batch_o.status = status_d;
  assign batch_o.error  = error_d;

  // Hold sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= ata_seq_pkg::PH_IDLE;
      ready_q  <= 1'b0;
      cop_q    <= '0;
      sector_q <= '0;
      left_q   <= '0;
      wi_q     <= '0;
      poll_q   <= '0;
      settle_q <= '0;
      status_q <= '0;
      error_q  <= '0;
      sig_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      ready_q  <= ready_d;
      cop_q    <= cop_d;
      sector_q <= sector_d;
      left_q   <= left_d;
      wi_q     <= wi_d;
      poll_q   <= poll_d;
      settle_q <= settle_d;
      status_q <= status_d;
      error_q  <= error_d;
      sig_q    <= sig_d;
    end
  end

endmodule
`default_nettype wire

// File: sv/ata_seq_queue.sv
// ----------------------------------------------------------------------------
// ata_seq_queue
// Batch queue between the sequencer and the result drain.
// ----------------------------------------------------------------------------
`default_nettype none
module ata_seq_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  ata_seq_pkg::batch_t  batch_i,
  output logic                 full_o,
  output logic                 empty_o,
  input  wire                  pop_i,
  output ata_seq_pkg::batch_t  batch_o
);

  ata_seq_pkg::batch_t slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign batch_o = slot_q[rp_q];

  // Store a batch.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= batch_i;
    end
  end

  // Advance pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule
`default_nettype wire

// File: sv/ata_seq_drain.sv
// ----------------------------------------------------------------------------
// ata_seq_drain
// Back part: sends the results of a queued batch one beat at a time.
// ----------------------------------------------------------------------------
`default_nettype none
module ata_seq_drain (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     empty_i,
  input  ata_seq_pkg::batch_t     batch_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  output ata_seq_pkg::out_item_t  out_data_o
);

  logic [2:0] idx_q;
  logic       fire, lastb;
  ata_seq_pkg::res_t r;

  assign r           = batch_i.res[idx_q];
  assign lastb       = ({1'b0, idx_q} + 4'd1 == batch_i.count);
  assign out_valid_o = !empty_i;
  assign fire        = out_valid_o && out_ready_i;
  assign pop_o       = fire && lastb;

  assign out_data_o.out_kind    = r.out_kind;
  assign out_data_o.bus_write   = r.bus_write;
  assign out_data_o.bus_reg     = r.bus_reg;
  assign out_data_o.bus_wide    = r.bus_wide;
  assign out_data_o.out_data    = r.out_data;
  assign out_data_o.done_code   = r.done_code;
  assign out_data_o.last_status = batch_i.status;
  assign out_data_o.last_error  = batch_i.error;
  assign out_data_o.last        = lastb;

  // Advance through the batch.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (fire) begin
      idx_q <= lastb ? 3'd0 : idx_q + 3'd1;
    end
  end

endmodule
`default_nettype wire

// File: sv/ata_pio_lba28_host_sequencer_top.sv
// ----------------------------------------------------------------------------
// ata_pio_lba28_host_sequencer_top
// ATA PIO LBA28 host sequencer for the primary master.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_ready_o   in_item_t
//   out      output     out_valid_o/out_ready_i out_item_t
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Each input item's results (up to eight) go out one beat per cycle while
// out_ready_i is high, from a two-batch queue, so input stalls only when the
// queue is full. Items causing no result are dropped at once. Reset restores
// the register defaults and the idle phase; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module ata_pio_lba28_host_sequencer_top #(
  parameter int unsigned WordsPerSector = 256,
  parameter int unsigned CountBits      = 16
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  ata_seq_pkg::in_item_t   in_data_i,
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  output ata_seq_pkg::out_item_t  out_data_o,
  input  wire                     cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire                     cfg_index_i,
  input  wire  [19:0]             cfg_data_i
);

  logic [19:0] poll_q;
  logic [3:0]  settle_q;
  logic        step, full, empty, pop, idle;
  ata_seq_pkg::batch_t eb, qb;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !full;
  assign step        = in_valid_i && in_ready_o;

  // Hold configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_q   <= ata_seq_pkg::POLL_RESET;
      settle_q <= ata_seq_pkg::SETTLE_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ata_seq_pkg::CFG_POLL:   poll_q   <= cfg_data_i;
        ata_seq_pkg::CFG_SETTLE: settle_q <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  ata_seq_engine #(.WordsPerSector(WordsPerSector), .CountBits(CountBits)) u_eng (
    .clk_i, .rst_ni, .step_i(step), .item_i(in_data_i), .poll_limit_i(poll_q),
    .settle_reads_i(settle_q), .batch_o(eb), .idle_o(idle)
  );

  ata_seq_queue u_q (
    .clk_i, .rst_ni, .push_i(step && eb.count != 4'd0), .batch_i(eb),
    .full_o(full), .empty_o(empty), .pop_i(pop), .batch_o(qb)
  );

  ata_seq_drain u_dr (
    .clk_i, .rst_ni, .empty_i(empty), .batch_i(qb), .pop_o(pop),
    .out_valid_o, .out_ready_i, .out_data_o
  );

  `ASSERT_IMPL(a_pop_valid, clk_i, rst_ni, pop, out_valid_o, "pop without valid")
  `ASSERT_IMPL(a_nonempty_batch, clk_i, rst_ni, !empty, qb.count != 4'd0, "empty batch queued")
  `ASSERT_IMPL(a_done_last, clk_i, rst_ni,
               out_valid_o && out_data_o.out_kind == ata_seq_pkg::KIND_DONE,
               out_data_o.last, "completion not last")
  `ASSERT_IMPL(a_idle_done, clk_i, rst_ni, step && eb.count != 4'd0 && idle && !$past(idle),
               1'b1, "idle check")

endmodule
`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ATA PIO LBA28 host sequencer. A device responder
// answers each bus read that the sequencer emits, with clean or faulty status
// bytes chosen per test. A behavioral model of the sequencer predicts every
// result beat, and a monitor compares the beats field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned Sector     = 256;

  // Fault injection choices for the device responder
  localparam int INJ_NONE   = 0;
  localparam int INJ_NODEV  = 1;
  localparam int INJ_NOTATA = 2;
  localparam int INJ_BSYTO  = 3;
  localparam int INJ_DRQERR = 4;
  localparam int INJ_DRQDF  = 5;
  localparam int INJ_DRQTO  = 6;
  localparam int INJ_STERR  = 7;
  localparam int INJ_STDF   = 8;
  localparam int INJ_RAND   = 9;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  ata_seq_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  ata_seq_pkg::out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_index = 1'b0;
  logic [19:0] cfg_data = '0;

  int unsigned cycles = 0;
  int          errors = 0;
  int          burst_left = 0;

  ata_pio_lba28_host_sequencer_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Sequencer model
  // --------------------------------------------------------------------------
  logic [19:0] poll_lim;
  logic [3:0]  settle_cfg;
  ata_seq_pkg::phase_e m_phase;
  logic        m_ready;
  logic [1:0]  m_op;
  logic [32:0] m_sector;
  logic [15:0] m_left;
  int unsigned m_word;
  int unsigned m_poll;
  logic [3:0]  m_settle;
  logic [7:0]  m_status;
  logic [7:0]  m_error;
  logic        m_sig;

  ata_seq_pkg::res_t      step_res[$];
  ata_seq_pkg::out_item_t expected_beats[$];

  function automatic void emit(logic [1:0] k, logic bw, logic [3:0] r, logic wd,
                               logic [15:0] d, logic [3:0] c);
    ata_seq_pkg::res_t x;
    if (step_res.size() >= ata_seq_pkg::MaxRes) return;
    x.out_kind  = k;
    x.bus_write = bw;
    x.bus_reg   = r;
    x.bus_wide  = wd;
    x.out_data  = d;
    x.done_code = c;
    step_res.push_back(x);
  endfunction

  function automatic void wr_reg(logic [3:0] r, logic [7:0] v);
    emit(ata_seq_pkg::KIND_BUS, 1'b1, r, 1'b0, {8'h00, v}, ata_seq_pkg::DC_OK);
  endfunction

  function automatic void rd_reg(logic [3:0] r);
    emit(ata_seq_pkg::KIND_BUS, 1'b0, r, 1'b0, '0, ata_seq_pkg::DC_OK);
  endfunction

  function automatic void rd_word();
    emit(ata_seq_pkg::KIND_BUS, 1'b0, ata_seq_pkg::REG_DATA, 1'b1, '0, ata_seq_pkg::DC_OK);
  endfunction

  function automatic void close_cmd(logic [3:0] code);
    emit(ata_seq_pkg::KIND_DONE, 1'b0, '0, 1'b0, '0, code);
    m_phase = ata_seq_pkg::PH_IDLE;
  endfunction

  function automatic int unsigned eff_limit();
    return (poll_lim == 0) ? 1 : poll_lim;
  endfunction

  function automatic void start_poll(ata_seq_pkg::phase_e ph);
    m_poll = 1;
    rd_reg(ata_seq_pkg::REG_CMD);
    m_phase = ph;
  endfunction

  function automatic void poll_again(logic [3:0] code);
    if (m_poll >= eff_limit()) begin
      close_cmd(code);
    end else begin
      m_poll++;
      rd_reg(ata_seq_pkg::REG_CMD);
    end
  endfunction

  function automatic void after_settle();
    if (m_op == ata_seq_pkg::OP_IDENT) begin
      wr_reg(ata_seq_pkg::REG_CNT, 8'h00);
      wr_reg(ata_seq_pkg::REG_LO, 8'h00);
      wr_reg(ata_seq_pkg::REG_MID, 8'h00);
      wr_reg(ata_seq_pkg::REG_HI, 8'h00);
      wr_reg(ata_seq_pkg::REG_CMD, ata_seq_pkg::CMD_IDENT);
      rd_reg(ata_seq_pkg::REG_CMD);
      m_phase = ata_seq_pkg::PH_ID_STATUS;
    end else if (m_op == ata_seq_pkg::OP_READ) begin
      rd_reg(ata_seq_pkg::REG_CMD);
      m_phase = ata_seq_pkg::PH_SELST;
    end else begin
      start_poll(ata_seq_pkg::PH_BSY_A);
    end
  endfunction

  function automatic void settle_or_go();
    if (m_settle > 0) begin
      rd_reg(ata_seq_pkg::REG_ALT);
      m_phase = ata_seq_pkg::PH_SETTLE;
    end else begin
      after_settle();
    end
  endfunction

  function automatic void select_sector();
    if (m_sector > {1'b0, ata_seq_pkg::MAX_LBA}) begin
      close_cmd(ata_seq_pkg::DC_LBA);
      return;
    end
    wr_reg(ata_seq_pkg::REG_DEV, ata_seq_pkg::DEV_LBA_MASTER | {4'h0, m_sector[27:24]});
    m_settle = settle_cfg;
    settle_or_go();
  endfunction

  function automatic void next_sector();
    m_left--;
    m_sector++;
    if (m_left == 0) close_cmd(ata_seq_pkg::DC_OK);
    else select_sector();
  endfunction

  function automatic void data_ready();
    m_word = 0;
    if (m_op == ata_seq_pkg::OP_IDENT) begin
      rd_word();
      m_phase = ata_seq_pkg::PH_ID_DATA;
    end else if (m_op == ata_seq_pkg::OP_READ) begin
      rd_word();
      m_phase = ata_seq_pkg::PH_RD_DATA;
    end else begin
      emit(ata_seq_pkg::KIND_REQW, 1'b0, '0, 1'b0, '0, ata_seq_pkg::DC_OK);
      m_phase = ata_seq_pkg::PH_WR_DATA;
    end
  endfunction

  function automatic void take_response(logic [15:0] v);
    logic [7:0] s;
    s = v[7:0];
    case (m_phase)
      ata_seq_pkg::PH_SETTLE: begin
        m_settle--;
        settle_or_go();
      end
      ata_seq_pkg::PH_SELST: start_poll(ata_seq_pkg::PH_BSY_A);
      ata_seq_pkg::PH_BSY_A: begin
        if (!(s & ata_seq_pkg::ST_BSY)) begin
          wr_reg(ata_seq_pkg::REG_CNT, 8'h01);
          wr_reg(ata_seq_pkg::REG_LO, m_sector[7:0]);
          wr_reg(ata_seq_pkg::REG_MID, m_sector[15:8]);
          wr_reg(ata_seq_pkg::REG_HI, m_sector[23:16]);
          wr_reg(ata_seq_pkg::REG_CMD, (m_op == ata_seq_pkg::OP_READ) ?
                 ata_seq_pkg::CMD_READ : ata_seq_pkg::CMD_WRITE);
          start_poll((m_op == ata_seq_pkg::OP_READ) ? ata_seq_pkg::PH_BSY_B
                                                    : ata_seq_pkg::PH_DRQ);
        end else begin
          poll_again(ata_seq_pkg::DC_BSYTO);
        end
      end
      ata_seq_pkg::PH_ID_STATUS: begin
        if (s == 0) close_cmd(ata_seq_pkg::DC_NODEV);
        else start_poll(ata_seq_pkg::PH_ID_BSY);
      end
      ata_seq_pkg::PH_ID_BSY: begin
        if (!(s & ata_seq_pkg::ST_BSY)) begin
          rd_reg(ata_seq_pkg::REG_MID);
          m_phase = ata_seq_pkg::PH_ID_MID;
        end else begin
          poll_again(ata_seq_pkg::DC_BSYTO);
        end
      end
      ata_seq_pkg::PH_ID_MID: begin
        m_sig = (s != 0);
        rd_reg(ata_seq_pkg::REG_HI);
        m_phase = ata_seq_pkg::PH_ID_HIGH;
      end
      ata_seq_pkg::PH_ID_HIGH: begin
        if (m_sig || s != 0) close_cmd(ata_seq_pkg::DC_NOTATA);
        else start_poll(ata_seq_pkg::PH_DRQ);
      end
      ata_seq_pkg::PH_DRQ: begin
        if (s & ata_seq_pkg::ST_ERR) begin
          m_status = s;
          rd_reg(ata_seq_pkg::REG_ERR);
          m_phase = ata_seq_pkg::PH_DRQ_ERR;
        end else if (s & ata_seq_pkg::ST_DF) begin
          m_status = s;
          close_cmd((m_op == ata_seq_pkg::OP_IDENT) ? ata_seq_pkg::DC_IDFAIL
                                                    : ata_seq_pkg::DC_DEVFLT);
        end else if (!(s & ata_seq_pkg::ST_BSY) && (s & ata_seq_pkg::ST_DRQ)) begin
          data_ready();
        end else if (m_poll >= eff_limit()) begin
          rd_reg(ata_seq_pkg::REG_CMD);
          m_phase = ata_seq_pkg::PH_DRQ_TO;
        end else begin
          m_poll++;
          rd_reg(ata_seq_pkg::REG_CMD);
        end
      end
      ata_seq_pkg::PH_DRQ_ERR: begin
        m_error = s;
        close_cmd((m_op == ata_seq_pkg::OP_IDENT) ? ata_seq_pkg::DC_IDFAIL
                                                  : ata_seq_pkg::DC_DEVERR);
      end
      ata_seq_pkg::PH_DRQ_TO: begin
        m_status = s;
        close_cmd((m_op == ata_seq_pkg::OP_IDENT) ? ata_seq_pkg::DC_IDFAIL
                                                  : ata_seq_pkg::DC_DRQTO);
      end
      ata_seq_pkg::PH_ID_DATA: begin
        m_word++;
        if (m_word < Sector) begin
          rd_word();
        end else begin
          m_ready = 1'b1;
          close_cmd(ata_seq_pkg::DC_OK);
        end
      end
      ata_seq_pkg::PH_BSY_B, ata_seq_pkg::PH_BSY_C: begin
        if (!(s & ata_seq_pkg::ST_BSY)) begin
          rd_reg(ata_seq_pkg::REG_CMD);
          m_phase = (m_phase == ata_seq_pkg::PH_BSY_B) ? ata_seq_pkg::PH_RD_ST
                                                       : ata_seq_pkg::PH_WR_ST;
        end else begin
          poll_again(ata_seq_pkg::DC_BSYTO);
        end
      end
      ata_seq_pkg::PH_RD_ST, ata_seq_pkg::PH_WR_ST: begin
        m_status = s;
        if (s & ata_seq_pkg::ST_ERR) begin
          rd_reg(ata_seq_pkg::REG_ERR);
          m_phase = ata_seq_pkg::PH_ERR_RD;
        end else if (s & ata_seq_pkg::ST_DF) begin
          close_cmd(ata_seq_pkg::DC_DEVFLT);
        end else if (m_phase == ata_seq_pkg::PH_WR_ST) begin
          next_sector();
        end else if (s & ata_seq_pkg::ST_DRQ) begin
          data_ready();
        end else begin
          start_poll(ata_seq_pkg::PH_DRQ);
        end
      end
      ata_seq_pkg::PH_ERR_RD: begin
        m_error = s;
        close_cmd(ata_seq_pkg::DC_DEVERR);
      end
      ata_seq_pkg::PH_RD_DATA: begin
        emit(ata_seq_pkg::KIND_RDW, 1'b0, '0, 1'b0, v, ata_seq_pkg::DC_OK);
        m_word++;
        if (m_word < Sector) rd_word();
        else next_sector();
      end
      default: ;
    endcase
  endfunction

  function automatic void take_command(ata_seq_pkg::in_item_t it);
    if (it.op == ata_seq_pkg::OP_IDENT) begin
      m_op = ata_seq_pkg::OP_IDENT;
      wr_reg(ata_seq_pkg::REG_DEV, ata_seq_pkg::DEV_LBA_MASTER);
      m_settle = settle_cfg;
      settle_or_go();
      return;
    end
    if (it.op > ata_seq_pkg::OP_WRITE) return;
    m_op = it.op;
    if (!m_ready) begin
      close_cmd(ata_seq_pkg::DC_NRDY);
    end else if (!it.has_buffer) begin
      close_cmd(ata_seq_pkg::DC_NOBUF);
    end else if (it.lba > ata_seq_pkg::MAX_LBA) begin
      close_cmd(ata_seq_pkg::DC_LBA);
    end else if (it.sector_count == 0) begin
      close_cmd(ata_seq_pkg::DC_OK);
    end else begin
      m_sector = {1'b0, it.lba};
      m_left   = it.sector_count;
      select_sector();
    end
  endfunction

  // Work out the beats caused by one accepted item and queue them
  function automatic void predict_beats(ata_seq_pkg::in_item_t it);
    ata_seq_pkg::out_item_t o;
    step_res.delete();
    case (it.req_type)
      ata_seq_pkg::REQ_CMD: if (m_phase == ata_seq_pkg::PH_IDLE) take_command(it);
      ata_seq_pkg::REQ_RESP: begin
        if (m_phase != ata_seq_pkg::PH_IDLE && m_phase != ata_seq_pkg::PH_WR_DATA)
          take_response(it.data_value);
      end
      ata_seq_pkg::REQ_WORD: begin
        if (m_phase == ata_seq_pkg::PH_WR_DATA) begin
          emit(ata_seq_pkg::KIND_BUS, 1'b1, ata_seq_pkg::REG_DATA, 1'b1, it.data_value,
               ata_seq_pkg::DC_OK);
          m_word++;
          if (m_word < Sector) emit(ata_seq_pkg::KIND_REQW, 1'b0, '0, 1'b0, '0,
                                    ata_seq_pkg::DC_OK);
          else start_poll(ata_seq_pkg::PH_BSY_C);
        end
      end
      default: ;
    endcase
    foreach (step_res[k]) begin
      o.out_kind    = step_res[k].out_kind;
      o.bus_write   = step_res[k].bus_write;
      o.bus_reg     = step_res[k].bus_reg;
      o.bus_wide    = step_res[k].bus_wide;
      o.out_data    = step_res[k].out_data;
      o.done_code   = step_res[k].done_code;
      o.last_status = m_status;
      o.last_error  = m_error;
      o.last        = (k == step_res.size() - 1);
      expected_beats.push_back(o);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Device responder: picks the value of the next response from the phase
  // --------------------------------------------------------------------------
  function automatic logic [15:0] device_value(int inj);
    logic [7:0] s;
    logic [7:0] hi;
    int         f;
    bit         busy;
    s  = 8'($urandom);
    hi = 8'($urandom);
    f  = inj;
    if (inj == INJ_RAND) f = ($urandom_range(0, 99) < 8) ? $urandom_range(1, 8) : INJ_NONE;
    case (m_phase)
      ata_seq_pkg::PH_ID_STATUS: s = (f == INJ_NODEV) ? 8'h00 : (s | 8'h40);
      ata_seq_pkg::PH_ID_MID: begin
        s = (f == INJ_NOTATA && $urandom_range(0, 1)) ? (s | 8'h01) : 8'h00;
      end
      ata_seq_pkg::PH_ID_HIGH: s = (f == INJ_NOTATA) ? (s | 8'h02) : 8'h00;
      ata_seq_pkg::PH_BSY_A, ata_seq_pkg::PH_ID_BSY, ata_seq_pkg::PH_BSY_B,
      ata_seq_pkg::PH_BSY_C: begin
        busy = (f == INJ_BSYTO) || ($urandom_range(0, 99) < ((poll_lim <= 4) ? 40 : 20));
        s = busy ? (s | ata_seq_pkg::ST_BSY) : (s & ~ata_seq_pkg::ST_BSY);
      end
      ata_seq_pkg::PH_DRQ: begin
        case (f)
          INJ_DRQERR: s = s | ata_seq_pkg::ST_ERR;
          INJ_DRQDF:  s = (s | ata_seq_pkg::ST_DF) & ~ata_seq_pkg::ST_ERR;
          INJ_DRQTO: begin
            s = (s | ata_seq_pkg::ST_BSY) & ~(ata_seq_pkg::ST_ERR | ata_seq_pkg::ST_DF);
          end
          default: begin
            if ($urandom_range(0, 4) == 0) begin
              s = s & ~(ata_seq_pkg::ST_ERR | ata_seq_pkg::ST_DF | ata_seq_pkg::ST_DRQ);
            end else begin
              s = (s | ata_seq_pkg::ST_DRQ) &
                  ~(ata_seq_pkg::ST_BSY | ata_seq_pkg::ST_ERR | ata_seq_pkg::ST_DF);
            end
          end
        endcase
      end
      ata_seq_pkg::PH_RD_ST, ata_seq_pkg::PH_WR_ST: begin
        if (f == INJ_STERR) s = s | ata_seq_pkg::ST_ERR;
        else if (f == INJ_STDF) s = (s | ata_seq_pkg::ST_DF) & ~ata_seq_pkg::ST_ERR;
        else s = s & ~(ata_seq_pkg::ST_ERR | ata_seq_pkg::ST_DF);
      end
      default: ;
    endcase
    return {hi, s};
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Send one beat in bursts with random gaps between them
  task automatic send_item(ata_seq_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (!in_ready);
    predict_beats(it);
  endtask

  task automatic hold_input();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Write one register once the sequencer is idle
  task automatic write_reg(logic idx, logic [19:0] v);
    hold_input();
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == ata_seq_pkg::CFG_POLL) poll_lim = v;
    else settle_cfg = v[3:0];
    @(posedge clk_i);
  endtask

  task automatic set_regs(logic [19:0] poll, logic [3:0] settle);
    write_reg(ata_seq_pkg::CFG_POLL, poll);
    write_reg(ata_seq_pkg::CFG_SETTLE, {16'h0, settle});
  endtask

  function automatic ata_seq_pkg::in_item_t junk_item();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(ata_seq_pkg::in_item_t)-1:0];
  endfunction

  // Issue a command and answer the sequencer until it completes
  task automatic run_cmd(logic [1:0] op, logic [31:0] lba, logic [15:0] cnt, logic has_buf,
                         int inj, bit noisy);
    ata_seq_pkg::in_item_t it;
    it = junk_item();
    it.req_type     = ata_seq_pkg::REQ_CMD;
    it.op           = op;
    it.lba          = lba;
    it.sector_count = cnt;
    it.has_buffer   = has_buf;
    send_item(it);
    while (m_phase != ata_seq_pkg::PH_IDLE) begin
      if (noisy && $urandom_range(0, 99) < 5) begin
        send_item(junk_item());
      end else begin
        it = junk_item();
        if (m_phase == ata_seq_pkg::PH_WR_DATA) begin
          it.req_type = ata_seq_pkg::REQ_WORD;
        end else begin
          it.req_type   = ata_seq_pkg::REQ_RESP;
          it.data_value = device_value(inj);
        end
        send_item(it);
      end
    end
  endtask

  task automatic send_kind(logic [1:0] rt);
    ata_seq_pkg::in_item_t it;
    it = junk_item();
    it.req_type = rt;
    send_item(it);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_not_ready();
    run_cmd(ata_seq_pkg::OP_READ, 32'h0, 16'd1, 1'b1, INJ_NONE, 0);
    run_cmd(ata_seq_pkg::OP_WRITE, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, INJ_NONE, 0);
    run_cmd(2'd3, 32'h0, 16'd1, 1'b1, INJ_NONE, 0);
    send_kind(2'd3);
    send_kind(ata_seq_pkg::REQ_RESP);
    send_kind(ata_seq_pkg::REQ_WORD);
  endtask

  task automatic test_identify_faults();
    set_regs(20'd0, 4'd0);
    run_cmd(ata_seq_pkg::OP_IDENT, 32'h0, 16'h0, 1'b0, INJ_NODEV, 0);
    run_cmd(ata_seq_pkg::OP_IDENT, 32'h0, 16'h0, 1'b0, INJ_NOTATA, 0);
    run_cmd(ata_seq_pkg::OP_IDENT, 32'h0, 16'h0, 1'b0, INJ_BSYTO, 0);
    run_cmd(ata_seq_pkg::OP_IDENT, 32'h0, 16'h0, 1'b0, INJ_DRQERR, 0);
    run_cmd(ata_seq_pkg::OP_IDENT, 32'h0, 16'h0, 1'b0, INJ_DRQDF, 0);
    set_regs(20'd2, 4'd1);
    run_cmd(ata_seq_pkg::OP_IDENT, 32'h0, 16'h0, 1'b0, INJ_DRQTO, 0);
  endtask

  task automatic test_identify();
    set_regs(20'hFFFFF, 4'd15);
    run_cmd(ata_seq_pkg::OP_IDENT, 32'h0, 16'h0, 1'b1, INJ_NONE, 0);
  endtask

  task automatic test_rejects();
    run_cmd(ata_seq_pkg::OP_READ, 32'h0, 16'd1, 1'b0, INJ_NONE, 0);
    run_cmd(ata_seq_pkg::OP_READ, 32'h1000_0000, 16'd1, 1'b1, INJ_NONE, 0);
    run_cmd(ata_seq_pkg::OP_WRITE, 32'hFFFF_FFFF, 16'd1, 1'b1, INJ_NONE, 0);
    run_cmd(ata_seq_pkg::OP_READ, ata_seq_pkg::MAX_LBA, 16'd0, 1'b1, INJ_NONE, 0);
    run_cmd(ata_seq_pkg::OP_WRITE, 32'h0, 16'd0, 1'b1, INJ_NONE, 0);
  endtask

  task automatic test_transfers();
    set_regs(ata_seq_pkg::POLL_RESET, ata_seq_pkg::SETTLE_RESET);
    run_cmd(ata_seq_pkg::OP_READ, 32'h0, 16'd1, 1'b1, INJ_NONE, 0);
    run_cmd(ata_seq_pkg::OP_WRITE, ata_seq_pkg::MAX_LBA, 16'd1, 1'b1, INJ_NONE, 0);
    run_cmd(ata_seq_pkg::OP_READ, ata_seq_pkg::MAX_LBA, 16'd2, 1'b1, INJ_NONE, 0);
    run_cmd(ata_seq_pkg::OP_READ, 32'h0ABC_DEF0, 16'hFFFF, 1'b1, INJ_STERR, 0);
    run_cmd(ata_seq_pkg::OP_WRITE, 32'h0000_00FF, 16'hFFFF, 1'b1, INJ_STDF, 0);
    run_cmd(ata_seq_pkg::OP_WRITE, 32'h0123_4567, 16'd1, 1'b1, INJ_DRQERR, 0);
    run_cmd(ata_seq_pkg::OP_WRITE, 32'h0123_4567, 16'd1, 1'b1, INJ_DRQDF, 0);
    set_regs(20'd2, 4'd0);
    run_cmd(ata_seq_pkg::OP_READ, 32'h0055_AA00, 16'd1, 1'b1, INJ_BSYTO, 0);
    run_cmd(ata_seq_pkg::OP_WRITE, 32'h0055_AA00, 16'd1, 1'b1, INJ_DRQTO, 0);
    run_cmd(ata_seq_pkg::OP_READ, 32'h0055_AA00, 16'd1, 1'b1, INJ_DRQTO, 0);
  endtask

  task automatic test_random();
    logic [1:0]  op;
    logic [31:0] lba;
    logic [15:0] cnt;
    int          pick;
    int          inj;
    for (int n = 0; n < 8; n++) begin
      if (n % 4 == 0) begin
        pick = $urandom_range(0, 6);
        set_regs((pick == 0) ? 20'd0 : (pick == 1) ? 20'd1 : (pick == 2) ? 20'hFFFFF :
                 (pick == 3) ? ata_seq_pkg::POLL_RESET : 20'($urandom_range(2, 40)),
                 ($urandom_range(0, 3) == 0) ? 4'd15 : 4'($urandom_range(0, 3)));
      end
      pick = $urandom_range(0, 99);
      op = (pick < 15) ? ata_seq_pkg::OP_IDENT : (pick < 55) ? ata_seq_pkg::OP_READ :
           (pick < 97) ? ata_seq_pkg::OP_WRITE : 2'd3;
      pick = $urandom_range(0, 99);
      lba = (pick < 85) ? ($urandom & ata_seq_pkg::MAX_LBA) :
            (pick < 92) ? (ata_seq_pkg::MAX_LBA - $urandom_range(0, 1)) : $urandom;
      pick = $urandom_range(0, 99);
      inj = INJ_RAND;
      if (pick < 70) begin
        cnt = 16'd1;
      end else if (pick < 85) begin
        cnt = 16'($urandom_range(2, 3));
      end else if (pick < 90) begin
        cnt = 16'd0;
      end else begin
        cnt = 16'($urandom);
        inj = INJ_STERR;
      end
      run_cmd(op, lba, cnt, ($urandom_range(0, 9) != 0), inj, 1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result monitor
  // --------------------------------------------------------------------------
  function automatic void check_field(string nm, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, nm, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    ata_seq_pkg::out_item_t e;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h", $time, out_data);
        errors++;
      end else begin
        e = expected_beats.pop_front();
        check_field("out_kind", 16'(e.out_kind), 16'(out_data.out_kind));
        check_field("bus_write", 16'(e.bus_write), 16'(out_data.bus_write));
        check_field("bus_reg", 16'(e.bus_reg), 16'(out_data.bus_reg));
        check_field("bus_wide", 16'(e.bus_wide), 16'(out_data.bus_wide));
        check_field("out_data", e.out_data, out_data.out_data);
        check_field("done_code", 16'(e.done_code), 16'(out_data.done_code));
        check_field("last_status", 16'(e.last_status), 16'(out_data.last_status));
        check_field("last_error", 16'(e.last_error), 16'(out_data.last_error));
        check_field("last", 16'(e.last), 16'(out_data.last));
      end
    end
  end

  // Receiver stalls: switch among open, random and periodic patterns
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(32, 256);
    end
    stall_left--;
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 99) >= 35);
      default: out_ready <= (stall_left % 3 != 0);
    endcase
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    poll_lim   = ata_seq_pkg::POLL_RESET;
    settle_cfg = ata_seq_pkg::SETTLE_RESET;
    m_phase    = ata_seq_pkg::PH_IDLE;
    m_ready    = 1'b0;
    m_op       = ata_seq_pkg::OP_IDENT;
    m_sector   = '0;
    m_left     = '0;
    m_word     = 0;
    m_poll     = 0;
    m_settle   = '0;
    m_status   = '0;
    m_error    = '0;
    m_sig      = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_not_ready();
    test_identify_faults();
    test_identify();
    test_rejects();
    test_transfers();
    test_random();
    hold_input();
    drain();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire
